FILE: design/rce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rce_pkg;

    localparam int MAX_WIDTH_DEF = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CMP_W      = 16;   // holds any row count and any line length
    localparam int GRAD_W     = 14;   // signed gradient, |g| <= 8160
    localparam int MAG_W      = 13;
    localparam int TERM_W     = 19;   // (13-bit magnitude * 8-bit gain) >> 2
    localparam int SUM_W      = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q2      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIMIT  = 3'd5;

    localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd480;
    localparam logic [15:0] RST_KERNEL_ONE   = 16'hF001;
    localparam logic [15:0] RST_KERNEL_TWO   = 16'h0F10;
    localparam logic [7:0]  RST_GAIN_Q2      = 8'd11;
    localparam logic [7:0]  RST_CLAMP_LIMIT  = 8'd125;

    typedef struct packed {
        logic [12:0] image_width;
        logic [15:0] image_height;
        logic [15:0] kernel_one;
        logic [15:0] kernel_two;
        logic [7:0]  gain_q2;
        logic [7:0]  clamp_limit;
    } t_cfg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GRAD,
        S_SCALE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic grad_en;
        logic scale_en;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    // Sum of four signed 4-bit coefficients times the window pixels
    function automatic logic signed [GRAD_W-1:0] window_grad(
        input logic [15:0] kern,
        input logic [7:0]  a,
        input logic [7:0]  b,
        input logic [7:0]  c,
        input logic [7:0]  d
    );
        logic signed [GRAD_W-1:0] p0, p1, p2, p3;
        p0 = $signed({{10{kern[3]}},  kern[3:0]})   * $signed({6'b0, a});
        p1 = $signed({{10{kern[7]}},  kern[7:4]})   * $signed({6'b0, b});
        p2 = $signed({{10{kern[11]}}, kern[11:8]})  * $signed({6'b0, c});
        p3 = $signed({{10{kern[15]}}, kern[15:12]}) * $signed({6'b0, d});
        return p0 + p1 + p2 + p3;
    endfunction

    function automatic logic [MAG_W-1:0] grad_mag(input logic signed [GRAD_W-1:0] g);
        logic signed [GRAD_W-1:0] neg;
        neg = -g;
        return g[GRAD_W-1] ? neg[MAG_W-1:0] : g[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/rce_pixel_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rce_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       start_of_frame;

    modport source (output valid, output pixel, output start_of_frame, input ready);
    modport sink   (input valid, input pixel, input start_of_frame, output ready);
endinterface

`default_nettype wire

FILE: design/rce_edge_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rce_edge_if;
    logic       valid;
    logic       ready;
    logic [7:0] edge_value;
    logic       position_valid;
    logic       last_of_frame;

    modport source (output valid, output edge_value, output position_valid,
                    output last_of_frame, input ready);
    modport sink   (input valid, input edge_value, input position_valid,
                    input last_of_frame, output ready);
endinterface

`default_nettype wire

FILE: design/rce_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rce_ctrl
    import rce_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_GRAD;
                end
            end
            S_GRAD: begin
                o_cmd.grad_en = 1'b1;
                n_state       = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale_en = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/rce_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rce_datapath
    import rce_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire t_cmd       i_cmd,
    output t_status         o_status,
    input  wire logic [7:0] i_pixel,
    input  wire logic       i_start_of_frame,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    output logic [7:0]      o_edge_value,
    output logic            o_position_valid,
    output logic            o_last_of_frame
);

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

    logic [7:0] line_store [MAX_WIDTH];

    logic [COL_W-1:0] r_col;
    logic [CMP_W-1:0] r_row;
    logic [7:0]       r_upper_left;
    logic [7:0]       r_cur_left;
    logic [7:0]       r_px;
    logic [7:0]       r_up;
    logic             r_edge_en;
    logic             r_pos_valid;
    logic             r_last;
    logic [MAG_W-1:0] r_mag1, r_mag2;
    logic [TERM_W-1:0] r_term1, r_term2;
    logic             r_out_valid;
    logic [7:0]       r_out_edge;
    logic             r_out_pos_valid;
    logic             r_out_last;

    logic [COL_W-1:0] eff_col;
    logic [CMP_W-1:0] eff_row;
    logic [CMP_W-1:0] w_eff, w_last, h_eff, h_last;
    logic             col_at_end_eff, row_at_end_eff;
    logic             col_at_end, row_at_end;
    logic [SUM_W-1:0] sum;
    logic [7:0]       edge_clamped;
    logic [MAG_W+8-1:0] prod1, prod2;

    // effective line length and frame height
    always_comb begin
        w_eff = {3'b0, i_cfg.image_width};
        if (w_eff < CMP_W'(2)) begin
            w_eff = CMP_W'(2);
        end else if (w_eff > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        w_last = w_eff - CMP_W'(1);
        h_eff  = (i_cfg.image_height < CMP_W'(2)) ? CMP_W'(2) : i_cfg.image_height;
        h_last = h_eff - CMP_W'(1);
    end

    assign eff_col        = i_start_of_frame ? '0 : r_col;
    assign eff_row        = i_start_of_frame ? '0 : r_row;
    assign col_at_end_eff = CMP_W'(eff_col) >= w_last;
    assign row_at_end_eff = eff_row >= h_last;
    assign col_at_end     = CMP_W'(r_col) >= w_last;
    assign row_at_end     = r_row >= h_last;

    // line store: read on acceptance, write back when the item completes
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_up <= line_store[eff_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            line_store[r_col] <= r_px;
        end
    end

    // position counters and left neighbours
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_upper_left <= '0;
            r_cur_left   <= '0;
        end else if (i_cmd.accept) begin
            r_col <= eff_col;
            r_row <= eff_row;
        end else if (i_cmd.finish) begin
            r_upper_left <= r_up;
            r_cur_left   <= r_px;
            if (col_at_end) begin
                r_col <= '0;
                r_row <= row_at_end ? '0 : r_row + CMP_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px        <= i_pixel;
            r_pos_valid <= (eff_row != '0) && (eff_col != '0);
            r_edge_en   <= (eff_row >= CMP_W'(2)) && (CMP_W'(eff_col) >= CMP_W'(2));
            r_last      <= row_at_end_eff && col_at_end_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad_en) begin
            r_mag1 <= grad_mag(window_grad(i_cfg.kernel_one, r_upper_left, r_up,
                                           r_cur_left, r_px));
            r_mag2 <= grad_mag(window_grad(i_cfg.kernel_two, r_upper_left, r_up,
                                           r_cur_left, r_px));
        end
    end

    assign prod1 = r_mag1 * i_cfg.gain_q2;
    assign prod2 = r_mag2 * i_cfg.gain_q2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale_en) begin
            r_term1 <= prod1[MAG_W+8-1:2];
            r_term2 <= prod2[MAG_W+8-1:2];
        end
    end

    always_comb begin
        sum = SUM_W'(r_term1) + SUM_W'(r_term2);
        if (!r_edge_en) begin
            edge_clamped = '0;
        end else if (sum > SUM_W'(i_cfg.clamp_limit)) begin
            edge_clamped = i_cfg.clamp_limit;
        end else begin
            edge_clamped = sum[7:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_edge      <= edge_clamped;
            r_out_pos_valid <= r_pos_valid;
            r_out_last      <= r_last;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_edge_value      = r_out_edge;
    assign o_position_valid  = r_out_pos_valid;
    assign o_last_of_frame   = r_out_last;

endmodule

`default_nettype wire

FILE: design/roberts_cross_edge_detector.sv
// Flow: an accepted pixel and its line store read are registered, then the gradient
// magnitudes, then the gain-multiplied terms; the sum/clamp enters the output register
// once free; only then is a new pixel accepted. A result waits there until taken.
// Reset: synchronous, active low; clears the registers to their defaults, the position
// counters, the left neighbours and both handshakes. The line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module roberts_cross_edge_detector
    import rce_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    rce_pixel_if.sink                  i_pix,
    rce_edge_if.source                 o_edge
);

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= RST_IMAGE_WIDTH;
            r_cfg.image_height <= RST_IMAGE_HEIGHT;
            r_cfg.kernel_one   <= RST_KERNEL_ONE;
            r_cfg.kernel_two   <= RST_KERNEL_TWO;
            r_cfg.gain_q2      <= RST_GAIN_Q2;
            r_cfg.clamp_limit  <= RST_CLAMP_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data[12:0];
                CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data;
                CFG_KERNEL_ONE:   r_cfg.kernel_one   <= i_cfg_data;
                CFG_KERNEL_TWO:   r_cfg.kernel_two   <= i_cfg_data;
                CFG_GAIN_Q2:      r_cfg.gain_q2      <= i_cfg_data[7:0];
                CFG_CLAMP_LIMIT:  r_cfg.clamp_limit  <= i_cfg_data[7:0];
                default: begin
                    // drop writes to unknown indices
                end
            endcase
        end
    end

    rce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rce_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_pixel          (i_pix.pixel),
        .i_start_of_frame (i_pix.start_of_frame),
        .i_out_ready      (o_edge.ready),
        .o_out_valid      (o_edge.valid),
        .o_edge_value     (o_edge.edge_value),
        .o_position_valid (o_edge.position_valid),
        .o_last_of_frame  (o_edge.last_of_frame)
    );

endmodule

`default_nettype wire
